### rtl/core/cfp_pkg.sv
// ----------------------------------------------------------------------------
// cfp_pkg: shared types and constants of the crossfade player
// Source count, memory geometry, word codes, sequencer states and the
// request word of the shared divide / square-root unit.
// ----------------------------------------------------------------------------
`default_nettype none
package cfp_pkg;

    localparam int SOURCES     = 6;
    localparam int MEM_DEPTH   = 65536;
    localparam int SAMPLE_BITS = 16;
    localparam int SRC_W       = 3;
    localparam int ADDR_W      = 16;
    localparam int MEM_AW      = SRC_W + ADDR_W;
    localparam int RAM_DEPTH   = SOURCES * MEM_DEPTH;
    localparam int POS_W       = 33;
    localparam int LEN_W       = 17;
    localparam int GAIN_W      = 16;
    localparam int ACC_W       = 36;
    localparam int OUT_W       = 19;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_W       = 32;

    localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'd32768;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PLAYBACK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USED     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMING0  = 3'd2;

    localparam logic [CFG_W-1:0] TIMING_RESET   = 32'd131074000;
    localparam logic [10:0]      PLAYBACK_RESET = 11'd2000;

    // Word opcodes
    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_TICK    = 2'd1,
        OP_RESTART = 2'd2,
        OP_NONE    = 2'd3
    } cfp_op_t;

    // Sequencer states
    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_GAIN = 8'b0000_0010,
        ST_FDIV = 8'b0000_0100,
        ST_SQRT = 8'b0000_1000,
        ST_INC  = 8'b0001_0000,
        ST_POS  = 8'b0010_0000,
        ST_RD   = 8'b0100_0000,
        ST_MAC  = 8'b1000_0000
    } cfp_state_t;

    // Request to the shared unit
    typedef struct packed {
        logic start;
        logic sqrt;
    } cfp_req_t;

endpackage
`default_nettype wire

### rtl/core/multi_source_crossfade_player_unit.sv
// ----------------------------------------------------------------------------
// multi_source_crossfade_player_unit: looped multi-source crossfade player
// Loads sample buffers, advances looped play positions and mixes the
// sources with equal-power crossfade gains.
// ----------------------------------------------------------------------------
// A load or restart word is taken in the idle state. A tick word walks the used
// sources one at a time through a single shared divide / square-root unit:
// per source the sequencer picks the gain, runs the fade division and the
// square root when the source sits inside a fade, divides for the position
// increment and then updates the position, reads memory and
// multiply-accumulates; with no used sources the tick marks its mix finished
// straight from the idle state. The finished mix is handed to the output
// register before the next word is accepted. The tick's
// word then waits in an output register while the next input word is
// accepted, and a finished mix that finds that register still full holds
// the input off until the waiting word is taken.
`default_nettype none
module multi_source_crossfade_player_unit
    import cfp_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_write,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [1:0]              opcode,
    input  wire logic [SRC_W-1:0]        source_id,
    input  wire logic [ADDR_W-1:0]       sample_address,
    input  wire logic signed [15:0]      sample_value,
    input  wire logic                    last_sample,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic signed [OUT_W-1:0]      mixed_sample
);

    cfp_state_t state_reg, state_next;

    logic [10:0]       pl_reg;
    logic [2:0]        used_cfg_reg;
    logic [CFG_W-1:0]  timing_reg [SOURCES];
    logic [LEN_W-1:0]  bl_reg [SOURCES];
    logic [POS_W-1:0]  pos_reg [SOURCES];

    logic [SRC_W-1:0]  idx_reg, idx_next;
    logic [2:0]        used_reg, used_next;
    logic [GAIN_W-1:0] gain_reg, gain_next;
    logic [31:0]       inc_reg, inc_next;
    logic signed [32:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic              fin_reg, fin_next;
    logic              out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0] out_reg, out_next;

    logic              accept;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_addr;
    logic [15:0]       mem_rdata;

    cfp_req_t          req;
    logic [15:0]       u_rem, u_div;
    logic [31:0]       u_operand;
    logic [5:0]        u_steps;
    logic              u_done;
    logic [31:0]       u_result;

    // Gain decision for the current source
    logic [15:0] pl16, cp, ci, cn;
    logic        g_unity, g_fade;
    logic [15:0] g_n, g_d;
    logic [SRC_W-1:0] idx_prev, idx_succ;

    // Position update for the current source
    logic [POS_W-1:0] pos_sum, pos_len, pos_new;
    logic [LEN_W-1:0] cur_len;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE) && !fin_reg;

    // Pick crossfade points and classify the gain
    always_comb
    begin
        pl16     = {5'd0, pl_reg};
        idx_prev = (idx_reg == '0) ? idx_reg : idx_reg - 3'd1;
        idx_succ = (idx_reg == SRC_W'(SOURCES - 1)) ? idx_reg : idx_reg + 3'd1;
        cp       = timing_reg[idx_prev][15:0];
        ci       = timing_reg[idx_reg][15:0];
        cn       = timing_reg[idx_succ][15:0];
        g_unity  = 1'b0;
        g_fade   = 1'b0;
        g_n      = '0;
        g_d      = '0;
        if (used_reg == 3'd1)
        begin
            g_unity = 1'b1;
        end
        else if (idx_reg == '0)
        begin
            if (pl16 <= ci)
            begin
                g_unity = 1'b1;
            end
            else if (pl16 < cn)
            begin
                g_fade = 1'b1;
                g_n    = cn - pl16;
                g_d    = cn - ci;
            end
        end
        else if (idx_reg == used_reg - 3'd1)
        begin
            if (pl16 >= ci)
            begin
                g_unity = 1'b1;
            end
            else if (pl16 > cp)
            begin
                g_fade = 1'b1;
                g_n    = pl16 - cp;
                g_d    = ci - cp;
            end
        end
        else
        begin
            if (pl16 > cp && pl16 < ci)
            begin
                g_fade = 1'b1;
                g_n    = pl16 - cp;
                g_d    = ci - cp;
            end
            else if (pl16 > ci && pl16 < cn)
            begin
                g_fade = 1'b1;
                g_n    = cn - pl16;
                g_d    = cn - ci;
            end
            else if (pl16 == ci)
            begin
                g_unity = 1'b1;
            end
        end
    end

    // Advance and wrap the play position
    always_comb
    begin
        cur_len = bl_reg[idx_reg];
        pos_sum = pos_reg[idx_reg] + {1'b0, inc_reg};
        pos_len = {cur_len, 16'd0};
        pos_new = (pos_sum >= pos_len) ? pos_sum - pos_len : pos_sum;
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        used_next      = used_reg;
        gain_next      = gain_reg;
        inc_next       = inc_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        req            = '0;
        u_rem          = '0;
        u_operand      = '0;
        u_div          = {5'd0, (pl_reg == 11'd0) ? 11'd1 : pl_reg};
        u_steps        = 6'd32;
        mem_we         = 1'b0;
        mem_addr       = {idx_reg, pos_new[31:16]};

        // Drop the output word once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Hand a finished mix to the output register
        if (fin_reg && (!out_valid_reg || out_ready))
        begin
            out_valid_next = 1'b1;
            out_next       = OUT_W'(acc_reg >>> 15);
            fin_next       = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                mem_addr = {source_id, sample_address};
                if (accept && opcode == OP_LOAD && source_id < SRC_W'(SOURCES))
                begin
                    mem_we = 1'b1;
                end
                if (accept && opcode == OP_TICK)
                begin
                    used_next = (used_cfg_reg > 3'(SOURCES)) ? 3'(SOURCES) : used_cfg_reg;
                    idx_next  = '0;
                    acc_next  = '0;
                    if (used_next == 3'd0)
                    begin
                        fin_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_GAIN;
                    end
                end
            end
            ST_GAIN:
            begin
                req.start = 1'b1;
                if (g_fade)
                begin
                    u_rem      = g_n;
                    u_div      = g_d;
                    u_steps    = 6'd30;
                    state_next = ST_FDIV;
                end
                else
                begin
                    gain_next  = g_unity ? UNITY_GAIN : '0;
                    u_operand  = {pl_reg == 11'd0 ? 16'd0 : 16'd0, 16'd0}
                               | {timing_reg[idx_reg][31:16], 16'd0};
                    state_next = ST_INC;
                end
            end
            ST_FDIV:
            begin
                if (u_done)
                begin
                    req.start  = 1'b1;
                    req.sqrt   = 1'b1;
                    u_operand  = {u_result[29:0], 2'b00};
                    u_steps    = 6'd15;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (u_done)
                begin
                    gain_next  = u_result[15:0];
                    req.start  = 1'b1;
                    u_operand  = {timing_reg[idx_reg][31:16], 16'd0};
                    state_next = ST_INC;
                end
            end
            ST_INC:
            begin
                if (u_done)
                begin
                    inc_next   = u_result;
                    state_next = ST_POS;
                end
            end
            ST_POS:
            begin
                if (cur_len == '0)
                begin
                    prod_next  = '0;
                    state_next = ST_MAC;
                end
                else
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                prod_next  = $signed({1'b0, gain_reg}) * $signed(mem_rdata);
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                acc_next = acc_reg + ACC_W'(prod_reg);
                idx_next = idx_reg + 3'd1;
                if (idx_reg + 3'd1 == used_reg)
                begin
                    fin_next   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_GAIN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pl_reg       <= PLAYBACK_RESET;
            used_cfg_reg <= '0;
            for (int i = 0; i < SOURCES; i++)
            begin
                timing_reg[i] <= TIMING_RESET;
            end
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_PLAYBACK)
            begin
                pl_reg <= cfg_data[10:0];
            end
            else if (cfg_index == REG_USED)
            begin
                used_cfg_reg <= cfg_data[2:0];
            end
            else
            begin
                for (int i = 0; i < SOURCES; i++)
                begin
                    if (cfg_index == REG_TIMING0 + CFG_IDX_W'(i))
                    begin
                        timing_reg[i] <= cfg_data;
                    end
                end
            end
        end
    end

    // Buffer lengths and play positions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SOURCES; i++)
            begin
                bl_reg[i]  <= '0;
                pos_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < SOURCES; i++)
            begin
                if (accept && opcode == OP_LOAD && last_sample
                    && source_id == SRC_W'(i))
                begin
                    bl_reg[i] <= {1'b0, sample_address} + 17'd1;
                end
                if (accept && opcode == OP_RESTART)
                begin
                    pos_reg[i] <= '0;
                end
                else if (state_reg == ST_POS && idx_reg == SRC_W'(i))
                begin
                    pos_reg[i] <= (cur_len == '0) ? '0 : pos_new;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        used_reg <= used_next;
        gain_reg <= gain_next;
        inc_reg  <= inc_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        out_reg  <= out_next;
    end

    cfp_iter u_iter (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rem_init (u_rem),
        .operand  (u_operand),
        .divisor  (u_div),
        .steps    (u_steps),
        .done     (u_done),
        .result   (u_result)
    );

    cfp_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (sample_value),
        .rdata (mem_rdata)
    );

    assign out_valid    = out_valid_reg;
    assign mixed_sample = out_reg;

endmodule
`default_nettype wire

### rtl/core/cfp_ram.sv
// ----------------------------------------------------------------------------
// cfp_ram: generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module cfp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write or read one entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

### rtl/core/cfp_iter.sv
// ----------------------------------------------------------------------------
// cfp_iter: shared iterative divide / square-root unit
// Restoring division, one quotient bit per cycle, and digit-by-digit square
// root, one root bit per cycle, over one compare-and-subtract datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module cfp_iter
    import cfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfp_req_t    req,
    input  wire logic [15:0] rem_init,
    input  wire logic [31:0] operand,
    input  wire logic [15:0] divisor,
    input  wire logic [5:0]  steps,
    output logic             done,
    output logic [31:0]      result
);

    logic [16:0] rem_reg, rem_next;
    logic [31:0] shf_reg, shf_next;
    logic [31:0] q_reg, q_next;
    logic [15:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        sqrt_reg, sqrt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    logic [18:0] a_op, b_op, diff;
    logic        ge;

    // Shared compare and subtract
    always_comb
    begin
        if (sqrt_reg)
        begin
            a_op = {rem_reg, shf_reg[31:30]};
            b_op = {q_reg[16:0], 2'b01};
        end
        else
        begin
            a_op = {2'b00, rem_reg[15:0], shf_reg[31]};
            b_op = {3'b000, d_reg};
        end
        ge   = (a_op >= b_op);
        diff = a_op - b_op;
    end

    // Advance one step
    always_comb
    begin
        rem_next  = rem_reg;
        shf_next  = shf_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        sqrt_next = sqrt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = {1'b0, rem_init};
            shf_next  = operand;
            q_next    = '0;
            d_next    = divisor;
            cnt_next  = steps;
            sqrt_next = req.sqrt;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[16:0] : a_op[16:0];
            q_next   = {q_reg[30:0], ge};
            shf_next = sqrt_reg ? {shf_reg[29:0], 2'b00} : {shf_reg[30:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        shf_reg  <= shf_next;
        q_reg    <= q_next;
        d_reg    <= d_next;
        cnt_reg  <= cnt_next;
        sqrt_reg <= sqrt_next;
    end

    assign done   = done_reg;
    assign result = q_reg;

endmodule
`default_nettype wire

### tb/sv/multi_source_crossfade_player_unit_tb.sv
// ----------------------------------------------------------------------------
// multi_source_crossfade_player_unit_tb: self-checking bench of the player
// Loads short looped buffers, walks the configuration through several
// settings and mixes random load, tick and restart words. A scoreboard
// class predicts every mixed sample and checks the output channel in order.
// ----------------------------------------------------------------------------
`default_nettype none
module multi_source_crossfade_player_unit_tb;
    import cfp_pkg::*;

    localparam int IDLE_LIMIT  = 20000;
    localparam int DRAIN_WAIT  = 600;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_WORDS = 85;
    localparam int BUF_SPAN    = 48;

    typedef struct {
        logic [1:0]        op;
        logic [SRC_W-1:0]  src;
        logic [ADDR_W-1:0] addr;
        logic [15:0]       val;
        logic              last;
    } player_word_t;

    // Scoreboard: mirror of the mixer state and the queue of pending samples
    class mix_scoreboard;
        logic signed [15:0] mem [SOURCES][MEM_DEPTH];
        bit                 written [SOURCES][MEM_DEPTH];
        bit [LEN_W-1:0]     blen [SOURCES];
        bit [POS_W-1:0]     pos [SOURCES];
        bit [10:0]          playback;
        bit [2:0]           used;
        bit [31:0]          timing [SOURCES];
        logic [OUT_W-1:0]   pending_mix [$];

        function new();
            for (int i = 0; i < SOURCES; i++)
            begin
                blen[i]   = '0;
                pos[i]    = '0;
                timing[i] = TIMING_RESET;
            end
            playback = PLAYBACK_RESET;
            used     = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
            if (idx == REG_PLAYBACK)
                playback = d[10:0];
            else if (idx == REG_USED)
                used = d[2:0];
            else if (idx >= REG_TIMING0)
                timing[idx - REG_TIMING0] = d;
        endfunction

        function bit [31:0] isqrt(longint unsigned v);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v   = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res[31:0];
        endfunction

        function bit [31:0] fade(bit [31:0] n, bit [31:0] d);
            longint unsigned q;
            if (d == 0)
                return 0;
            q = ({32'd0, n} << 30) / {32'd0, d};
            return isqrt(q);
        endfunction

        // Gain of one source from the sorted crossfade points
        function bit [31:0] gain_of(int i, int u);
            bit [31:0] pl, cp, ci, cn;
            pl = {21'd0, playback};
            if (u == 0 || i >= u)
                return 0;
            if (u == 1)
                return {16'd0, UNITY_GAIN};
            if (i == 0)
            begin
                cp = {16'd0, timing[0][15:0]};
                cn = {16'd0, timing[1][15:0]};
                if (pl <= cp)
                    return {16'd0, UNITY_GAIN};
                if (pl < cn)
                    return fade((cn - cp) - (pl - cp), cn - cp);
                return 0;
            end
            cp = {16'd0, timing[i-1][15:0]};
            ci = {16'd0, timing[i][15:0]};
            if (i == u - 1)
            begin
                if (pl >= ci)
                    return {16'd0, UNITY_GAIN};
                if (pl > cp)
                    return fade(pl - cp, ci - cp);
                return 0;
            end
            cn = {16'd0, timing[i+1][15:0]};
            if (pl > cp && pl < ci)
                return fade(pl - cp, ci - cp);
            if (pl > ci && pl < cn)
                return fade((cn - ci) - (pl - ci), cn - ci);
            if (pl == ci)
                return {16'd0, UNITY_GAIN};
            return 0;
        endfunction

        function int used_now();
            return (used > SOURCES) ? SOURCES : used;
        endfunction

        // Advanced position of one source for the next tick
        function bit [POS_W-1:0] advance(int i);
            longint unsigned dv, inc, p, len;
            dv  = (playback == 0) ? 1 : playback;
            inc = ({48'd0, timing[i][31:16]} << 16) / dv;
            len = {47'd0, blen[i]} << 16;
            p   = ({31'd0, pos[i]} + inc) & 64'h1_FFFF_FFFF;
            if (p >= len)
                p = p - len;
            return p[POS_W-1:0];
        endfunction

        // Find a sample that the next tick would read before it was loaded
        function bit unloaded_read(output int s, output int a);
            bit [POS_W-1:0] p;
            for (int i = 0; i < used_now(); i++)
            begin
                if (blen[i] != 0)
                begin
                    p = advance(i);
                    if (!written[i][p[31:16]])
                    begin
                        s = i;
                        a = int'(p[31:16]);
                        return 1;
                    end
                end
            end
            return 0;
        endfunction

        function void note_word(player_word_t w);
            longint acc, g, smp, r;
            int u;
            case (w.op)
                OP_LOAD:
                begin
                    if (w.src < SOURCES)
                    begin
                        mem[w.src][w.addr]     = w.val;
                        written[w.src][w.addr] = 1;
                        if (w.last)
                            blen[w.src] = {1'b0, w.addr} + 17'd1;
                    end
                end
                OP_RESTART:
                begin
                    for (int i = 0; i < SOURCES; i++)
                        pos[i] = '0;
                end
                OP_TICK:
                begin
                    acc = 0;
                    u = used_now();
                    for (int i = 0; i < u; i++)
                    begin
                        if (blen[i] == 0)
                            pos[i] = '0;
                        else
                        begin
                            pos[i] = advance(i);
                            g   = gain_of(i, u);
                            smp = mem[i][pos[i][31:16]];
                            acc = acc + g * smp;
                        end
                    end
                    r = acc >>> 15;
                    pending_mix.push_back(r[OUT_W-1:0]);
                end
                default: ;
            endcase
        endfunction

        // Compare one output word with the oldest pending sample
        function bit check_mix(logic [OUT_W-1:0] got, output logic [OUT_W-1:0] want,
                               output bit orphan);
            orphan = (pending_mix.size() == 0);
            want = '0;
            if (orphan)
                return 0;
            want = pending_mix.pop_front();
            return (got === want);
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_W-1:0]         cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [1:0]               opcode = OP_NONE;
    logic [SRC_W-1:0]         source_id = '0;
    logic [ADDR_W-1:0]        sample_address = '0;
    logic signed [15:0]       sample_value = '0;
    logic                     last_sample = 1'b0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [OUT_W-1:0]  mixed_sample;

    mix_scoreboard sb = new();
    int errors = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int next_addr [SOURCES];

    multi_source_crossfade_player_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .source_id(source_id), .sample_address(sample_address),
        .sample_value(sample_value), .last_sample(last_sample),
        .out_valid(out_valid), .out_ready(out_ready), .mixed_sample(mixed_sample)
    );

    always #2 clk = ~clk;

    task automatic report(string msg);
        $display("MISMATCH: %s", msg);
        errors++;
    endtask

    // Check every output word
    always @(posedge clk)
    begin
        logic [OUT_W-1:0] want;
        bit orphan;
        if (out_valid && out_ready)
        begin
            if (!sb.check_mix(mixed_sample, want, orphan))
            begin
                if (orphan)
                    report($sformatf("mixed_sample %0h with nothing pending", mixed_sample));
                else
                    report($sformatf("mixed_sample got %0h want %0h", mixed_sample, want));
            end
        end
    end

    // Watchdog: count cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Output stall pattern, with one long hold-off early in the run
    initial
    begin
        int run;
        int mode;
        @(posedge rst_n);
        repeat (3000) @(posedge clk) out_ready <= ($urandom_range(0, 1) == 1);
        @(posedge clk) out_ready <= 1'b0;
        repeat (1500) @(posedge clk);
        forever
        begin
            run  = $urandom_range(5, 80);
            mode = $urandom_range(0, 2);
            repeat (run)
            begin
                @(posedge clk);
                if (mode == 0)
                    out_ready <= 1'b1;
                else if (mode == 1)
                    out_ready <= ($urandom_range(0, 1) == 1);
                else
                    out_ready <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        sb.write_reg(idx, d);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Offer one word, hold it until accepted, then maybe leave a gap
    task automatic send_word(player_word_t w);
        in_valid       <= 1'b1;
        opcode         <= w.op;
        source_id      <= w.src;
        sample_address <= w.addr;
        sample_value   <= w.val;
        last_sample    <= w.last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_word(w);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 30);
        end
        else
            burst_left--;
    endtask

    function automatic player_word_t make_word(logic [1:0] op, int src, int addr,
                                               int val, bit last);
        player_word_t w;
        w.op   = op;
        w.src  = SRC_W'(src);
        w.addr = ADDR_W'(addr);
        w.val  = 16'(val);
        w.last = last;
        return w;
    endfunction

    // Send a tick, or first load a sample that it would read unloaded
    task automatic send_tick();
        int s, a;
        while (sb.unloaded_read(s, a))
            send_word(make_word(OP_LOAD, s, a, $urandom, 1'b0));
        send_word(make_word(OP_TICK, $urandom, $urandom, $urandom, 1'($urandom)));
    endtask

    // Drop valid right at the accepting edge, then wait for the output
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_mix.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic configure_phase(int p);
        logic [10:0] pl;
        logic [31:0] t;
        int pt, region;
        case (p)
            0: pl = 11'd100;
            1: pl = 11'd2000;
            2: pl = 11'd0;
            3: pl = 11'd2047;
            default: pl = 11'($urandom_range(100, 2000));
        endcase
        write_reg(REG_PLAYBACK, {21'($urandom), pl});
        write_reg(REG_USED, {29'($urandom), 3'((p + 1) % 8)});
        pt = $urandom_range(0, 400);
        for (int i = 0; i < SOURCES; i++)
        begin
            region = $urandom_range(0, 3 * ((pl == 0) ? 1 : pl));
            t = {16'(region), 16'(pt)};
            if (p == 5)
                t = $urandom;
            else if (p == 6)
                t = (i % 2 == 0) ? 32'h0 : 32'hFFFF_FFFF;
            write_reg(REG_TIMING0 + CFG_IDX_W'(i), t);
            pt = pt + $urandom_range(1, 500);
        end
    endtask

    // Mostly well-formed buffer loads, ticks and restarts, with some noise
    task automatic random_word();
        int kind, s;
        bit last;
        kind = $urandom_range(0, 99);
        if (kind < 45)
        begin
            s = $urandom_range(0, SOURCES - 1);
            last = ($urandom_range(0, 3) == 0);
            send_word(make_word(OP_LOAD, s, next_addr[s], $urandom, last));
            next_addr[s] = (next_addr[s] + 1) % BUF_SPAN;
        end
        else if (kind < 85)
            send_tick();
        else if (kind < 90)
            send_word(make_word(OP_RESTART, $urandom, $urandom, $urandom, 1'($urandom)));
        else
        begin
            // noise: a no-op or a load word at any address, never setting a length
            send_word(make_word((kind % 2 == 0) ? OP_NONE : OP_LOAD, $urandom, $urandom,
                                $urandom, 1'b0));
        end
    endtask

    initial
    begin
        for (int i = 0; i < SOURCES; i++)
            next_addr[i] = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: no used sources, then empty buffers
        send_tick();
        drain();
        write_reg(REG_USED, 32'd6);
        send_tick();
        // Two-sample buffers with extreme samples
        for (int i = 0; i < SOURCES; i++)
        begin
            send_word(make_word(OP_LOAD, i, 0, -32768, 1'b0));
            send_word(make_word(OP_LOAD, i, 1, 32767, 1'b1));
        end
        send_word(make_word(OP_LOAD, 7, 16'hFFFF, 16'h5555, 1'b1));
        send_word(make_word(OP_LOAD, 0, 16'hFFFF, 16'hAAAA, 1'b0));
        send_word(make_word(OP_NONE, 7, 16'hFFFF, 16'hFFFF, 1'b1));
        send_tick();
        send_tick();
        send_word(make_word(OP_RESTART, 0, 0, 0, 1'b0));
        send_tick();
        drain();
        write_reg(REG_USED, 32'd7);
        send_tick();
        drain();
        for (int i = 0; i < SOURCES; i++)
            next_addr[i] = 2;

        // Random phases over several settings
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            configure_phase(p);
            repeat (PHASE_WORDS) random_word();
            drain();
        end

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire
